>>> rtl/cfsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfsh_pkg;

  // Hash constants
  localparam logic [63:0] FnvBasis   = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] Golden     = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] FinalMul   = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] EmptyHash  = FnvBasis ^ Golden;
  localparam int unsigned FoldShift  = 33;
  localparam int unsigned MixShift   = 29;
  localparam logic [15:0] CohBase    = 16'd15000;
  localparam logic [15:0] EntBase    = 16'd12000;

  // Message queue depth between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Configuration register byte addresses
  localparam logic [2:0] AddrSalt = 3'd0;

  // Finished message handed from front to back
  typedef struct packed {
    logic        empty;
    logic [63:0] acc;
    logic [63:0] count;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_FIN
  } back_state_t;

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41 : 8'h5A]}) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  // One FNV-1a step: xor the byte, multiply by 2^40 + 0x1B3 as shift-adds
  function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
    logic [63:0] x;
    x = acc ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cfsh_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsh_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire cfsh_pkg::job_t         push_job,
  input  wire logic                   pop,
  output cfsh_pkg::job_t              head_job,
  output cfsh_pkg::q_status_t         status
);
  import cfsh_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_job     = entries[rd_ptr];
  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

>>> rtl/cfsh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsh_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_stall,
  input  wire logic                   kind,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire cfsh_pkg::q_status_t    q_status,
  output logic                        push,
  output cfsh_pkg::job_t              push_job
);
  import cfsh_pkg::*;

  logic [63:0] acc;
  logic [63:0] count;
  logic [63:0] acc_next;
  logic [63:0] count_next;
  logic        accept;

  // Hold the input while the queue has no room
  assign byte_stall = q_status.full;
  assign accept     = byte_valid && !byte_stall;

  // Fold and hash the incoming byte
  assign acc_next   = fnv_step(acc, fold_upper(data_byte));
  assign count_next = count + 64'd1;

  // Hand a finished message to the back end
  always_comb begin
    push           = accept && (kind || last_byte);
    push_job.empty = kind;
    push_job.acc   = acc_next;
    push_job.count = count_next;
  end

  // Update accumulator; drop back to basis at message end
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= FnvBasis;
      count <= '0;
    end else if (accept) begin
      if (kind || last_byte) begin
        acc   <= FnvBasis;
        count <= '0;
      end else begin
        acc   <= acc_next;
        count <= count_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/cfsh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfsh_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [31:0]            salt_value,
  input  wire cfsh_pkg::job_t         head_job,
  input  wire cfsh_pkg::q_status_t    q_status,
  output logic                        pop,
  output logic                        seed_valid,
  input  wire logic                   seed_stall,
  output logic [63:0]                 seed_word,
  output logic [31:0]                 check_word,
  output logic [15:0]                 coherence_seed,
  output logic [15:0]                 entropy_seed
);
  import cfsh_pkg::*;

  // Multiplier schedule: issue at a step, registered product consumed at the next step
  localparam logic [3:0] StepCntLo  = 4'd0;
  localparam logic [3:0] StepCntHiG = 4'd1;
  localparam logic [3:0] StepCntLoH = 4'd2;
  localparam logic [3:0] StepSaltLo = 4'd3;
  localparam logic [3:0] StepSaltHi = 4'd4;
  localparam logic [3:0] StepMixLo  = 4'd5;
  localparam logic [3:0] StepMixHiF = 4'd6;
  localparam logic [3:0] StepMixLoH = 4'd7;
  localparam logic [3:0] StepLast   = 4'd8;

  back_state_t state;
  back_state_t state_next;
  logic [3:0]  step;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] len_term;
  logic [63:0] salt_term;
  logic [63:0] mix_acc;
  logic [63:0] pre_mix;
  logic [63:0] folded;
  logic [63:0] mixed;
  logic [63:0] seed;
  logic        out_load;

  // Fold before the final multiply, mix after it, then apply empty value and salt
  assign pre_mix = head_job.acc ^ len_term;
  assign folded  = pre_mix ^ (pre_mix >> FoldShift);
  assign mixed   = mix_acc ^ (mix_acc >> MixShift);
  assign seed    = (head_job.empty ? EmptyHash : mixed) ^ salt_term;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_MUL;
      BK_MUL:  if (step == StepLast) state_next = BK_FIN;
      BK_FIN:  if (out_load) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    out_load = 1'b0;
    case (state)
      BK_FIN:  out_load = !seed_valid || !seed_stall;
      default: out_load = 1'b0;
    endcase
  end
  assign pop = out_load;

  // Select multiplier operands for this step
  always_comb begin
    case (step)
      StepCntLo:  begin op_a = head_job.count[31:0];  op_b = Golden[31:0];   end
      StepCntHiG: begin op_a = head_job.count[31:0];  op_b = Golden[63:32];  end
      StepCntLoH: begin op_a = head_job.count[63:32]; op_b = Golden[31:0];   end
      StepSaltLo: begin op_a = salt_value;            op_b = Golden[31:0];   end
      StepSaltHi: begin op_a = salt_value;            op_b = Golden[63:32];  end
      StepMixLo:  begin op_a = folded[31:0];          op_b = FinalMul[31:0]; end
      StepMixHiF: begin op_a = folded[31:0];          op_b = FinalMul[63:32]; end
      StepMixLoH: begin op_a = folded[63:32];         op_b = FinalMul[31:0]; end
      default:    begin op_a = '0;                    op_b = '0;             end
    endcase
  end

  // Sequencer state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == BK_MUL) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  // Shared multiplier and partial-product accumulators
  always_ff @(posedge clk) begin
    prod <= {32'd0, op_a} * {32'd0, op_b};
    if (state == BK_MUL) begin
      case (step)
        StepCntHiG: len_term  <= prod;
        StepCntLoH: len_term  <= len_term + {prod[31:0], 32'd0};
        StepSaltLo: len_term  <= len_term + {prod[31:0], 32'd0};
        StepSaltHi: salt_term <= prod;
        StepMixLo:  salt_term <= salt_term + {prod[31:0], 32'd0};
        StepMixHiF: mix_acc   <= prod;
        StepMixLoH: mix_acc   <= mix_acc + {prod[31:0], 32'd0};
        StepLast:   mix_acc   <= mix_acc + {prod[31:0], 32'd0};
        default:    mix_acc   <= mix_acc;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
    end else if (out_load) begin
      seed_valid <= 1'b1;
    end else if (!seed_stall) begin
      seed_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      seed_word      <= seed;
      check_word     <= seed[63:32] ^ seed[31:0] ^ salt_value;
      coherence_seed <= CohBase + {1'b0, seed[14:0]};
      entropy_seed   <= EntBase + {1'b0, seed[29:15]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/case_folded_fnv1a_seed_hash_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                  Moves
// byte      byte_valid/byte_stall, kind, data_byte,   one message byte or empty message
//           last_byte
// seed      seed_valid/seed_stall, seed_word,         one seed per finished message
//           check_word, coherence_seed, entropy_seed
// apb       psel/penable/pwrite/paddr/pwdata/prdata   salt register at address 0
//
// The front end takes one byte item per cycle unless byte_stall holds it;
// the FNV step is shift-adds. For each finished message the back end's one
// shared 32x32 multiplier works through eight partial products in sequence.
// The message queue holds QUEUE_DEPTH finished messages; byte_stall rises
// when it is full. seed_stall holds the output register and then the back end.
// Reset clears salt to zero, the accumulator to the FNV basis and the queue.

module case_folded_fnv1a_seed_hash_unit #(
  parameter int unsigned QUEUE_DEPTH = cfsh_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             seed_valid,
  input  wire logic        seed_stall,
  output logic [63:0]      seed_word,
  output logic [31:0]      check_word,
  output logic [15:0]      coherence_seed,
  output logic [15:0]      entropy_seed,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cfsh_pkg::*;

  logic        [31:0] salt_value;
  logic               push;
  logic               pop;
  job_t               push_job;
  job_t               head_job;
  q_status_t          q_status;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      salt_value <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == AddrSalt[2])) begin
      salt_value <= pwdata;
    end
  end
  assign prdata = (paddr[2] == AddrSalt[2]) ? salt_value : '0;

  cfsh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  cfsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  cfsh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .salt_value     (salt_value),
    .head_job       (head_job),
    .q_status       (q_status),
    .pop            (pop),
    .seed_valid     (seed_valid),
    .seed_stall     (seed_stall),
    .seed_word      (seed_word),
    .check_word     (check_word),
    .coherence_seed (coherence_seed),
    .entropy_seed   (entropy_seed)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("message pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("back end finished with no queued message");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_check_fold: assert property (@(posedge clk) disable iff (rst)
    seed_valid |-> (check_word == (seed_word[63:32] ^ seed_word[31:0] ^ salt_value)))
    else $error("check word does not match seed and salt");
`endif

endmodule

`default_nettype wire

>>> verif/tb_case_folded_fnv1a_seed_hash_unit.sv
`timescale 1ns / 1ps

module tb_case_folded_fnv1a_seed_hash_unit;

  // Hash constants for the predictor
  localparam logic [63:0] FNV_OFFSET  = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] BYTE_MUL    = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] GOLDEN_MUL  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL     = 64'hFF51_AFD7_ED55_8CCD;

  // Item kinds and register addresses
  localparam logic        KIND_BYTE   = 1'b0;
  localparam logic        KIND_EMPTY  = 1'b1;
  localparam logic [2:0]  ADDR_UNUSED = 3'd4;

  localparam int PHASE_ITEMS = 155;
  localparam int NUM_PHASES  = 6;
  localparam int SETTLE      = 16;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    logic [63:0] seed;
    logic [31:0] check;
    logic [15:0] coh;
    logic [15:0] ent;
  } seed_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic       typed;
    seed_t      want;
  } dir_row_t;

  // Empty message with zero salt: basis XOR golden, no finalizer
  localparam seed_t EMPTY_SEED = '{64'h55C5_E55D_FB68_5F30, 32'hAEAD_BA6D, 16'd39368, 16'd42416};

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic        kind;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        seed_valid;
  logic        seed_stall;
  logic [63:0] seed_word;
  logic [31:0] check_word;
  logic [15:0] coherence_seed;
  logic [15:0] entropy_seed;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [63:0] fnv_acc;
  logic [63:0] msg_len;
  logic [31:0] salt_model;

  seed_t    pending_seeds[$];
  dir_row_t dir_rows[DIR_ROWS];
  int       errors;
  int       sent;
  int       stall_left;
  bit       quiet;

  case_folded_fnv1a_seed_hash_unit dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .seed_valid    (seed_valid),
    .seed_stall    (seed_stall),
    .seed_word     (seed_word),
    .check_word    (check_word),
    .coherence_seed(coherence_seed),
    .entropy_seed  (entropy_seed),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL case_folded_fnv1a_seed_hash_unit");
    $finish;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  // Apply the salt and derive the 16-bit unsigned seeds
  function automatic seed_t finish_seed(input logic [63:0] h);
    seed_t r;
    r.seed  = h ^ ({32'd0, salt_model} * GOLDEN_MUL);
    r.check = r.seed[63:32] ^ r.seed[31:0] ^ salt_model;
    r.coh   = cfsh_pkg::CohBase + {1'b0, r.seed[14:0]};
    r.ent   = cfsh_pkg::EntBase + {1'b0, r.seed[29:15]};
    return r;
  endfunction

  // Advance the hash by one item; return 1 when it yields a seed
  function automatic bit predict_seed(input logic k, input logic [7:0] b, input logic l,
                                      output seed_t r);
    logic [7:0]  folded;
    logic [63:0] h;
    r = '0;
    if (k == KIND_EMPTY) begin
      fnv_acc = FNV_OFFSET;
      msg_len = '0;
      r = finish_seed(FNV_OFFSET ^ GOLDEN_MUL);
      return 1'b1;
    end
    folded  = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    fnv_acc = (fnv_acc ^ {56'd0, folded}) * BYTE_MUL;
    msg_len = msg_len + 64'd1;
    if (!l) begin
      return 1'b0;
    end
    h = fnv_acc ^ (msg_len * GOLDEN_MUL);
    h = h ^ (h >> cfsh_pkg::FoldShift);
    h = h * MIX_MUL;
    h = h ^ (h >> cfsh_pkg::MixShift);
    fnv_acc = FNV_OFFSET;
    msg_len = '0;
    r = finish_seed(h);
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Bias toward letters so case folding gets exercised
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h41, 8'h5A));
      1: return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until accepted, then log its expected seed if it yields one
  task automatic send_item(input logic k, input logic [7:0] b, input logic l,
                           input bit typed, input seed_t want);
    int    gap;
    bit    has;
    seed_t got;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    kind       <= k;
    data_byte  <= b;
    last_byte  <= l;
    do @(posedge clk); while (byte_stall);
    has = predict_seed(k, b, l, got);
    if (has) begin
      pending_seeds.push_back(typed ? want : got);
    end
    sent++;
  endtask

  // Drop valid and hold until every seed is back and the back end is quiet
  task automatic wait_idle();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending_seeds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, then read the salt back
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_cycle(1'b1, addr, value, rd);
    if (addr == cfsh_pkg::AddrSalt) begin
      salt_model = value;
    end
    apb_cycle(1'b0, cfsh_pkg::AddrSalt, '0, rd);
    check_field("salt readback", {32'd0, salt_model}, {32'd0, rd});
  endtask

  // One message: mostly short, a few long, some empty, some cut by an empty item
  task automatic send_message();
    int pick;
    int len;
    int cut;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) begin
      quiet = !quiet;
    end
    if (pick < 10) begin
      send_item(KIND_EMPTY, rand_byte(), 1'($urandom), 1'b0, '0);
    end else begin
      len = (pick < 95) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      cut = (pick >= 85 && pick < 95 && len > 1) ? $urandom_range(1, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == cut) begin
          send_item(KIND_EMPTY, rand_byte(), 1'($urandom), 1'b0, '0);
        end
        send_item(KIND_BYTE, rand_byte(), 1'(i == len - 1), 1'b0, '0);
      end
    end
  endtask

  // Check each accepted seed against the oldest expectation
  always @(posedge clk) begin
    seed_t want;
    if (!rst && seed_valid && !seed_stall) begin
      if (pending_seeds.size() == 0) begin
        $display("%0t ns: unexpected seed: expected none, got %h", $time, seed_word);
        errors++;
      end else begin
        want = pending_seeds.pop_front();
        check_field("seed_word", want.seed, seed_word);
        check_field("check_word", {32'd0, want.check}, {32'd0, check_word});
        check_field("coherence_seed", {48'd0, want.coh}, {48'd0, coherence_seed});
        check_field("entropy_seed", {48'd0, want.ent}, {48'd0, entropy_seed});
      end
      stall_left = draw_wait();
    end
  end

  // Hold the result side off for the drawn number of cycles
  initial begin
    forever begin
      @(negedge clk);
      seed_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  initial begin
    logic [31:0] phase_salt[NUM_PHASES];
    int          phase_end;
    bit          drained;
    rst        = 1'b1;
    byte_valid = 1'b0;
    kind       = KIND_BYTE;
    data_byte  = '0;
    last_byte  = 1'b0;
    seed_stall = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    errors     = 0;
    sent       = 0;
    stall_left = 0;
    quiet      = 1'b0;
    fnv_acc    = FNV_OFFSET;
    msg_len    = '0;
    salt_model = '0;

    // Directed items: empty messages, byte extremes, fold edges, cut message
    dir_rows = '{
      '{KIND_EMPTY, 8'h00, 1'b0, 1'b1, EMPTY_SEED},
      '{KIND_EMPTY, 8'hFF, 1'b1, 1'b1, EMPTY_SEED},
      '{KIND_BYTE,  8'h00, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'hFF, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h41, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h5A, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h40, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h5B, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h60, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h61, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h7A, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h7B, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h48, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h69, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h68, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h49, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h12, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h80, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_EMPTY, 8'hAA, 1'b0, 1'b1, EMPTY_SEED},
      '{KIND_BYTE,  8'h55, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h01, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h02, 1'b0, 1'b0, seed_t'('0)},
      '{KIND_BYTE,  8'h03, 1'b1, 1'b0, seed_t'('0)},
      '{KIND_EMPTY, 8'h5A, 1'b1, 1'b1, EMPTY_SEED}
    };
    phase_salt = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, $urandom, $urandom, 32'h0};

    // Hold reset, release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].want);
    end
    wait_idle();

    // A write to an unmapped address must leave the salt alone
    write_reg(ADDR_UNUSED, 32'hDEAD_BEEF);

    // Random messages under a series of salts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_reg(cfsh_pkg::AddrSalt, phase_salt[ph]);
      quiet     = (ph == 3);
      drained   = 1'b0;
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        send_message();
        // Let the pipeline empty once mid-run
        if (ph == 1 && !drained && sent >= phase_end - PHASE_ITEMS / 2) begin
          wait_idle();
          drained = 1'b1;
        end
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("PASS case_folded_fnv1a_seed_hash_unit");
    end else begin
      $display("FAIL case_folded_fnv1a_seed_hash_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cfsh_pkg.sv
rtl/cfsh_queue.sv
rtl/cfsh_front.sv
rtl/cfsh_back.sv
rtl/case_folded_fnv1a_seed_hash_unit.sv
verif/tb_case_folded_fnv1a_seed_hash_unit.sv
